>>> rtl/mt19937_br_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_br_pkg: shared constants and helpers
// Table geometry, generator constants, the one-word twist step and the
// output tempering of the 32-bit Mersenne Twister.
// ----------------------------------------------------------------------------
package mt19937_br_pkg;

  // table geometry
  localparam int unsigned StateWords  = 624;
  localparam int unsigned ShiftOffset = 397;
  localparam int unsigned AddrW       = $clog2(StateWords);

  localparam logic [AddrW-1:0] LastAddr  = AddrW'(StateWords - 1);
  localparam logic [AddrW:0]   FarOffset = (AddrW + 1)'(ShiftOffset);
  localparam logic [AddrW:0]   WrapWords = (AddrW + 1)'(StateWords);

  // generator constants
  localparam logic [31:0] TwistMatrix = 32'h9908_b0df;
  localparam logic [31:0] HighBit     = 32'h8000_0000;
  localparam logic [31:0] LowBits     = 32'h7fff_ffff;
  localparam logic [31:0] SeedMult    = 32'd1812433253;
  localparam logic [31:0] TemperB     = 32'h9d2c_5680;
  localparam logic [31:0] TemperC     = 32'hefc6_0000;

  // new value of one table word from its own, its successor and the far word
  function automatic logic [31:0] twist_word(logic [31:0] cur, logic [31:0] nxt,
                                             logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & HighBit) | (nxt & LowBits);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TwistMatrix;
    end
    return v;
  endfunction

  // output tempering
  function automatic logic [31:0] temper(logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // operand of the seeding multiply
  function automatic logic [31:0] seed_mix(logic [31:0] prev);
    return prev ^ (prev >> 30);
  endfunction

endpackage

>>> rtl/mt19937_bounded_random_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_bounded_random_unit: MT19937 draws reduced to a range
// Keeps the 624-word state in one single-port synchronous memory, twists
// each word just before it is used and returns the tempered word modulo
// the requested range through a restoring divider.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction | payload
//  ---------+----------------------------------+-----------+------------------
//  request  | in_valid_i / in_stall_o          | in        | range_i
//  result   | out_valid_o / out_stall_i        | out       | value_o, range_error_o
//  seed     | cfg_valid_i / cfg_ready_o        | in        | seed_i
//
//  After a request is taken the unit reads the word, its successor and the far
//  word, twists the word and writes it back, tempers it, runs 32 remainder
//  steps and loads the output register; the next request is taken back in idle.
//  Reset and every seed write refill the table, with requests stalled.
//  A finished result waits in the output register while the next request is
//  taken; the unit stalls only before writing a second result into it.
// ----------------------------------------------------------------------------
module mt19937_bounded_random_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] range_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic        range_error_o,
  // seed write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] seed_i
);

  localparam int unsigned AddrW = mt19937_br_pkg::AddrW;

  // state codes
  localparam logic [3:0] StSeed  = 4'd0;
  localparam logic [3:0] StFMul  = 4'd1;
  localparam logic [3:0] StFWr   = 4'd2;
  localparam logic [3:0] StIdle  = 4'd3;
  localparam logic [3:0] StRdNxt = 4'd4;
  localparam logic [3:0] StRdFar = 4'd5;
  localparam logic [3:0] StTwist = 4'd6;
  localparam logic [3:0] StTemp  = 4'd7;
  localparam logic [3:0] StDiv   = 4'd8;
  localparam logic [3:0] StDone  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [31:0]      seed_q;
  logic             out_valid_q, out_valid_d;

  logic [31:0] prev_q, prev_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] nxt_q, nxt_d;
  logic [31:0] word_q, word_d;
  logic [31:0] range_q, range_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] value_q, value_d;
  logic        err_q, err_d;

  // memory port
  logic [31:0]      mem [mt19937_br_pkg::StateWords];
  logic [31:0]      rdata_q;
  logic [AddrW-1:0] mem_addr;
  logic [31:0]      mem_wdata;
  logic             mem_we;

  // neighbour addresses of the current word
  logic [AddrW-1:0] ptr_next;
  logic [AddrW:0]   far_sum;
  logic [AddrW-1:0] far_addr;
  logic [32:0]      rem_shift;
  logic [32:0]      rem_sub;
  logic             in_take;
  logic             out_take;
  logic             out_free;

  assign ptr_next = (ptr_q == mt19937_br_pkg::LastAddr) ? '0 : ptr_q + 1'b1;
  assign far_sum  = {1'b0, ptr_q} + mt19937_br_pkg::FarOffset;
  assign far_addr = (far_sum >= mt19937_br_pkg::WrapWords)
                  ? AddrW'(far_sum - mt19937_br_pkg::WrapWords)
                  : far_sum[AddrW-1:0];

  // one restoring step of the remainder unit
  assign rem_shift = {rem_q, quo_q[31]};
  assign rem_sub   = rem_shift - {1'b0, range_q};

  // handshakes
  assign in_stall_o  = (state_q != StIdle);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign value_o       = value_q;
  assign range_error_o = err_q;

  // state table memory, one access a cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    prev_d      = prev_q;
    prod_d      = prod_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    word_d      = word_q;
    range_d     = range_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    value_d     = value_q;
    err_d       = err_q;
    mem_addr    = ptr_q;
    mem_wdata   = '0;
    mem_we      = 1'b0;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StSeed: begin
        mem_addr  = '0;
        mem_wdata = seed_q;
        mem_we    = 1'b1;
        prev_d    = seed_q;
        fill_d    = AddrW'(1);
        ptr_d     = '0;
        state_d   = StFMul;
      end
      StFMul: begin
        prod_d  = 32'(mt19937_br_pkg::seed_mix(prev_q) * mt19937_br_pkg::SeedMult);
        state_d = StFWr;
      end
      StFWr: begin
        mem_addr  = fill_q;
        mem_wdata = prod_q + {{(32 - AddrW){1'b0}}, fill_q};
        mem_we    = 1'b1;
        prev_d    = mem_wdata;
        fill_d    = fill_q + 1'b1;
        state_d   = (fill_q == mt19937_br_pkg::LastAddr) ? StIdle : StFMul;
      end
      StIdle: begin
        // read the word to be twisted
        mem_addr = ptr_q;
        if (in_take) begin
          range_d = range_i;
          state_d = StRdNxt;
        end
      end
      StRdNxt: begin
        mem_addr = ptr_next;
        cur_d    = rdata_q;
        state_d  = StRdFar;
      end
      StRdFar: begin
        mem_addr = far_addr;
        nxt_d    = rdata_q;
        state_d  = StTwist;
      end
      StTwist: begin
        // twist in place, then step on
        mem_addr  = ptr_q;
        mem_wdata = mt19937_br_pkg::twist_word(cur_q, nxt_q, rdata_q);
        mem_we    = 1'b1;
        word_d    = mem_wdata;
        ptr_d     = ptr_next;
        state_d   = StTemp;
      end
      StTemp: begin
        quo_d   = mt19937_br_pkg::temper(word_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        if (!rem_sub[32]) begin
          rem_d = rem_sub[31:0];
        end else begin
          rem_d = rem_shift[31:0];
        end
        quo_d = {quo_q[30:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          if (range_q == '0) begin
            value_d = '0;
            err_d   = 1'b1;
          end else begin
            value_d = rem_q;
            err_d   = 1'b0;
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StSeed;
      end
    endcase

    // a seed write refills the table from word 0
    if (cfg_valid_i && cfg_ready_o) begin
      state_d = StSeed;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StSeed;
      ptr_q       <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      seed_q      <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= seed_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    prod_q  <= prod_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    word_q  <= word_d;
    range_q <= range_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    value_q <= value_d;
    err_q   <= err_d;
  end

endmodule

>>> tb/sv/mt19937_bounded_random_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_bounded_random_unit_tb: self-checking bench for the bounded MT19937
// Drives range requests and seed writes into the unit. A scoreboard keeps
// its own copy of the 624-word generator state, works out each draw as a
// request is accepted and compares every result against it in order.
// Covers reseeding at the seed extremes, zero ranges, table regeneration
// and back-pressure on both channels.
// ----------------------------------------------------------------------------
module mt19937_bounded_random_unit_tb;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 50;
  localparam int unsigned NumDirected   = 20;

  localparam bit [31:0] DirectedRanges [NumDirected] = '{
    32'd0,          32'd1,          32'd2,          32'd3,
    32'hffff_ffff,  32'hffff_fffe,  32'h8000_0000,  32'h7fff_ffff,
    32'h8000_0001,  32'd10,         32'd100,        32'd1000,
    32'h0001_0000,  32'haaaa_aaaa,  32'h5555_5555,  32'd0,
    32'd6,          32'h0000_ffff,  32'hffff_0000,  32'd7
  };

  // expected draw
  typedef struct packed {
    logic [31:0] value;
    logic        range_error;
  } draw_t;

  // generator mirror and queue of outstanding draws
  class draw_scoreboard;
    bit [31:0]   mt_words [mt19937_br_pkg::StateWords];
    int unsigned word_ptr;
    draw_t       pending_q [$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
      reseed(32'd0);
    endfunction

    // standard seeding recurrence, regeneration armed
    function void reseed(bit [31:0] seed_val);
      bit [31:0] prev;
      mt_words[0] = seed_val;
      for (int k = 1; k < mt19937_br_pkg::StateWords; k++) begin
        prev        = mt_words[k-1];
        mt_words[k] = mt19937_br_pkg::SeedMult * (prev ^ (prev >> 30)) + 32'(k);
      end
      word_ptr = mt19937_br_pkg::StateWords;
    endfunction

    // in-place twist of the whole table
    function void regenerate();
      bit [31:0] y;
      bit [31:0] v;
      for (int k = 0; k < mt19937_br_pkg::StateWords; k++) begin
        y = (mt_words[k] & mt19937_br_pkg::HighBit) |
            (mt_words[(k + 1) % mt19937_br_pkg::StateWords] & mt19937_br_pkg::LowBits);
        v = mt_words[(k + mt19937_br_pkg::ShiftOffset) % mt19937_br_pkg::StateWords] ^
            (y >> 1);
        if (y[0]) begin
          v = v ^ mt19937_br_pkg::TwistMatrix;
        end
        mt_words[k] = v;
      end
      word_ptr = 0;
    endfunction

    function bit [31:0] scramble(bit [31:0] w);
      bit [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & mt19937_br_pkg::TemperB);
      y = y ^ ((y << 15) & mt19937_br_pkg::TemperC);
      y = y ^ (y >> 18);
      return y;
    endfunction

    // accepted request: draw a word, reduce it, queue the outcome
    function void note_request(bit [31:0] modulus);
      draw_t     exp_d;
      bit [31:0] w;
      if (word_ptr >= mt19937_br_pkg::StateWords) begin
        regenerate();
      end
      w        = scramble(mt_words[word_ptr]);
      word_ptr = word_ptr + 1;
      if (modulus == 32'd0) begin
        exp_d.value       = 32'd0;
        exp_d.range_error = 1'b1;
      end else begin
        exp_d.value       = w % modulus;
        exp_d.range_error = 1'b0;
      end
      pending_q.push_back(exp_d);
    endfunction

    // accepted result against the oldest outstanding draw
    function void check_result(logic [31:0] value, logic range_error);
      draw_t exp_d;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value %h range_error %b", $time, value,
                 range_error);
        fail_count++;
        return;
      end
      exp_d = pending_q.pop_front();
      if (value !== exp_d.value) begin
        $display("%0t: value mismatch expected %h actual %h", $time, exp_d.value, value);
        fail_count++;
      end
      if (range_error !== exp_d.range_error) begin
        $display("%0t: range_error mismatch expected %b actual %b", $time,
                 exp_d.range_error, range_error);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [31:0] range_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [31:0] value_o;
  logic        range_error_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] seed_i        = '0;

  draw_scoreboard sb;
  int unsigned    snd_idle_pct = 0;
  int unsigned    rcv_idle_pct = 0;
  int unsigned    idle_cycles  = 0;
  bit             hold_start   = 1'b0;
  logic           hold_req     = 1'b0;

  mt19937_bounded_random_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .range_i       (range_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .range_error_o (range_error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .seed_i        (seed_i)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= hold_req || ($urandom_range(99) < rcv_idle_pct);
  end

  // one long receiver hold-off, counted here
  initial begin
    wait (hold_start);
    hold_req <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_req <= 1'b0;
  end

  // handshake monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.reseed(seed_i);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(range_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(value_o, range_error_o);
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic bit [31:0] random_modulus();
    bit [31:0] sh;
    sh = 32'($urandom_range(31));
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'($urandom_range(16, 1));
      2:       return 32'($urandom_range(1000, 1));
      3:       return 32'd1 << sh;
      4:       return (32'd1 << sh) - 32'd1;
      5:       return 32'hffff_ffff - 32'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  // offer one request, with random gaps, and hold it until taken
  task automatic drive_request(input bit [31:0] modulus);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    range_i    <= modulus;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic random_requests(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      drive_request(random_modulus());
    end
    in_valid_i <= 1'b0;
  endtask

  // wait until every outstanding draw has come back
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_seed(input bit [31:0] seed_val);
    cfg_valid_i <= 1'b1;
    seed_i      <= seed_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ranges on the reset seed
    for (int i = 0; i < NumDirected; i++) begin
      drive_request(DirectedRanges[i]);
    end
    in_valid_i <= 1'b0;
    wait_drained();

    // all-ones seed, slow receiver
    write_seed(32'hffff_ffff);
    snd_idle_pct = 28;
    rcv_idle_pct = 73;
    random_requests(520);
    wait_drained();

    // random seed, slow sender
    write_seed($urandom());
    snd_idle_pct = 73;
    rcv_idle_pct = 28;
    random_requests(520);
    wait_drained();

    // zero seed, full rate with a long hold-off once the table is refilled
    write_seed(32'd0);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_requests(5);
    hold_start   = 1'b1;
    random_requests(245);
    wait_drained();
    random_requests(250);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mt19937_br_pkg.sv
rtl/mt19937_bounded_random_unit.sv
tb/sv/mt19937_bounded_random_unit_tb.sv
